/* rtl/sitd_pkg.sv */
// Shared constants, types and microcode table of the signed integer to decimal text core.
`timescale 1ns / 1ps

package sitd_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int IN_WIDTH    = 64;
    localparam int NUM_DIGITS  = 20;
    localparam int BCD_WIDTH   = 4 * NUM_DIGITS;
    localparam int ITER_WIDTH  = $clog2(VALUE_WIDTH + 1);
    localparam int DCNT_WIDTH  = $clog2(NUM_DIGITS + 1);
    localparam int CHAR_WIDTH  = 7;
    localparam int STEP_WIDTH  = 3;

    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 7'h2D;

    typedef logic [STEP_WIDTH-1:0] step_t;

    localparam step_t STEP_IDLE   = 3'd0;
    localparam step_t STEP_DABBLE = 3'd1;
    localparam step_t STEP_NORM   = 3'd2;
    localparam step_t STEP_SIGN   = 3'd3;
    localparam step_t STEP_DIGITS = 3'd4;
    localparam step_t STEP_DONE   = 3'd5;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_START,
        COND_BITS_LEFT,
        COND_LEAD_ZERO,
        COND_MORE_DIGITS
    } cond_t;

    typedef struct packed {
        logic  load;
        logic  dabble;
        logic  norm;
        logic  emit_sign;
        logic  emit_digit;
        cond_t cond;
        step_t target;
    } ctrl_t;

    function automatic ctrl_t microcode(input step_t step);
        ctrl_t w;
        w = '{load: 1'b0, dabble: 1'b0, norm: 1'b0, emit_sign: 1'b0,
              emit_digit: 1'b0, cond: COND_ALWAYS, target: STEP_IDLE};
        case (step)
            STEP_IDLE:
            begin
                w.load   = 1'b1;
                w.cond   = COND_NO_START;
                w.target = STEP_IDLE;
            end
            STEP_DABBLE:
            begin
                w.dabble = 1'b1;
                w.cond   = COND_BITS_LEFT;
                w.target = STEP_DABBLE;
            end
            STEP_NORM:
            begin
                w.norm   = 1'b1;
                w.cond   = COND_LEAD_ZERO;
                w.target = STEP_NORM;
            end
            STEP_SIGN:
            begin
                w.emit_sign = 1'b1;
                w.cond      = COND_NEVER;
            end
            STEP_DIGITS:
            begin
                w.emit_digit = 1'b1;
                w.cond       = COND_MORE_DIGITS;
                w.target     = STEP_DIGITS;
            end
            STEP_DONE:
            begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_IDLE;
            end
            default:
            begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

/* rtl/signed_int_to_decimal_text_core.sv */
// Top level: microcoded binary to decimal ASCII converter for signed integers.
`timescale 1ns / 1ps

// Takes one signed integer per start beat while busy is low and emits its decimal text,
// most significant character first, one beat per cycle on valid; a leading '-' marks a
// negative value and last_char marks the final digit. Busy stays high for each whole item, so
// a new item is taken only once the last is through: VALUE_WIDTH shift-add-3 steps, a
// leading-zero strip loop, the sign step, the digit loop and the closing step of the microcode.
// Beats cannot be held off; the receiver must take each valid beat in its cycle.
module signed_int_to_decimal_text_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [sitd_pkg::IN_WIDTH-1:0]    value,
    output logic                             busy,
    output logic                             valid,
    output logic [sitd_pkg::CHAR_WIDTH-1:0]  character,
    output logic                             last_char
);
    import sitd_pkg::*;

    step_t                   pc_reg, pc_next;
    logic [ITER_WIDTH-1:0]   iter_reg, iter_next;
    logic [DCNT_WIDTH-1:0]   dcnt_reg, dcnt_next;
    logic                    neg_reg, neg_next;
    logic [VALUE_WIDTH-1:0]  mag_reg, mag_next;
    logic [BCD_WIDTH-1:0]    bcd_reg, bcd_next;
    logic                    valid_reg, valid_next;
    logic [CHAR_WIDTH-1:0]   char_reg, char_next;
    logic                    last_reg, last_next;

    ctrl_t                   ctrl;
    logic                    cond_true;
    logic [VALUE_WIDTH-1:0]  in_bits;
    logic                    in_sign;
    logic [BCD_WIDTH-1:0]    bcd_adj;
    logic [3:0]              top_digit;
    logic                    lead_zero;

    assign ctrl      = microcode(pc_reg);
    assign in_bits   = value[VALUE_WIDTH-1:0];
    assign in_sign   = in_bits[VALUE_WIDTH-1];
    assign top_digit = bcd_reg[BCD_WIDTH-1 -: 4];
    assign lead_zero = (top_digit == 4'd0) && (dcnt_reg != DCNT_WIDTH'(1));

    always_comb
    begin
        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            if (bcd_reg[4*d +: 4] >= 4'd5)
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            else
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4];
        end
    end

    always_comb
    begin
        case (ctrl.cond)
            COND_NEVER:       cond_true = 1'b0;
            COND_ALWAYS:      cond_true = 1'b1;
            COND_NO_START:    cond_true = !start;
            COND_BITS_LEFT:   cond_true = (iter_reg != ITER_WIDTH'(1));
            COND_LEAD_ZERO:   cond_true = lead_zero;
            COND_MORE_DIGITS: cond_true = (dcnt_reg != DCNT_WIDTH'(1));
            default:          cond_true = 1'b0;
        endcase
    end

    always_comb
    begin
        pc_next    = cond_true ? ctrl.target : step_t'(pc_reg + 1'b1);
        iter_next  = iter_reg;
        dcnt_next  = dcnt_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        bcd_next   = bcd_reg;
        valid_next = 1'b0;
        char_next  = char_reg;
        last_next  = last_reg;

        // load a new item
        if (ctrl.load && start)
        begin
            neg_next  = in_sign;
            mag_next  = in_sign ? (~in_bits + 1'b1) : in_bits;
            bcd_next  = '0;
            iter_next = ITER_WIDTH'(VALUE_WIDTH);
            dcnt_next = DCNT_WIDTH'(NUM_DIGITS);
        end

        // shift one magnitude bit into the corrected decimal digits
        if (ctrl.dabble)
        begin
            {bcd_next, mag_next} = {bcd_adj, mag_reg} << 1;
            iter_next            = iter_reg - 1'b1;
        end

        // drop a leading zero digit
        if (ctrl.norm && lead_zero)
        begin
            bcd_next  = bcd_reg << 4;
            dcnt_next = dcnt_reg - 1'b1;
        end

        if (ctrl.emit_sign && neg_reg)
        begin
            valid_next = 1'b1;
            char_next  = CHAR_MINUS;
            last_next  = 1'b0;
        end

        // emit the top digit and advance
        if (ctrl.emit_digit)
        begin
            valid_next = 1'b1;
            char_next  = CHAR_ZERO + {3'b000, top_digit};
            last_next  = (dcnt_reg == DCNT_WIDTH'(1));
            bcd_next   = bcd_reg << 4;
            dcnt_next  = dcnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg    <= STEP_IDLE;
            iter_reg  <= '0;
            dcnt_reg  <= '0;
            neg_reg   <= 1'b0;
            mag_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg    <= pc_next;
            iter_reg  <= iter_next;
            dcnt_reg  <= dcnt_next;
            neg_reg   <= neg_next;
            mag_reg   <= mag_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg  <= bcd_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign busy      = (pc_reg != STEP_IDLE);
    assign valid     = valid_reg;
    assign character = char_reg;
    assign last_char = last_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_beat_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        valid_next |-> (pc_reg == STEP_SIGN || pc_reg == STEP_DIGITS))
        else $error("result beat outside an emit step");

    a_digits_left: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == STEP_DIGITS) |-> (dcnt_reg != '0))
        else $error("digit loop ran with no digits left");

    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && character == CHAR_MINUS) |-> !last_char)
        else $error("minus sign marked as last character");

endmodule

/* tb/sitd_text_checker.sv */
// Checker for the signed integer to decimal text core: predicts each number's text and compares beats.
`timescale 1ns / 1ps

module sitd_text_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic                             busy,
    input  logic [sitd_pkg::IN_WIDTH-1:0]    value,
    input  logic                             valid,
    input  logic [sitd_pkg::CHAR_WIDTH-1:0]  character,
    input  logic                             last_char,
    output int                               fail_count,
    output int                               beats_owed
);
    import sitd_pkg::*;

    typedef struct packed {
        logic [CHAR_WIDTH-1:0] ch;
        logic                  last;
    } text_beat_t;

    text_beat_t text_q[$];
    text_beat_t oldest;
    int         fail_total = 0;

    assign fail_count = fail_total;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        fail_total++;
    endtask

    function automatic void queue_text(input logic [IN_WIDTH-1:0] raw);
        logic [VALUE_WIDTH-1:0] v;
        logic [VALUE_WIDTH-1:0] magnitude;
        logic                   negative;
        logic [3:0]             digits [NUM_DIGITS];
        int                     count;
        text_beat_t             beat;
        v         = raw[VALUE_WIDTH-1:0];
        negative  = v[VALUE_WIDTH-1];
        magnitude = negative ? (~v + 1'b1) : v;
        count     = 0;
        do
        begin
            digits[count] = 4'(magnitude % 10);
            magnitude     = magnitude / 10;
            count++;
        end
        while (magnitude != 0 && count < NUM_DIGITS);
        if (negative)
        begin
            beat.ch   = CHAR_MINUS;
            beat.last = 1'b0;
            text_q.push_back(beat);
        end
        for (int i = count - 1; i >= 0; i--)
        begin
            beat.ch   = CHAR_WIDTH'(CHAR_ZERO + digits[i]);
            beat.last = (i == 0);
            text_q.push_back(beat);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_q.delete();
            beats_owed <= 0;
        end
        else
        begin
            if (valid)
            begin
                if (text_q.size() == 0)
                    report_mismatch($sformatf("character %h with no text pending", character));
                else
                begin
                    oldest = text_q.pop_front();
                    if (character !== oldest.ch)
                        report_mismatch($sformatf("character %h, predicted %h",
                                                  character, oldest.ch));
                    if (last_char !== oldest.last)
                        report_mismatch($sformatf("last_char %b, predicted %b on character %h",
                                                  last_char, oldest.last, oldest.ch));
                end
            end
            if (start && !busy)
                queue_text(value);
            beats_owed <= text_q.size();
        end
    end

endmodule

/* tb/tb_signed_int_to_decimal_text_core.sv */
// Testbench top: drives numbers into the decimal text core and reports the verdict.
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_text_core;
    import sitd_pkg::*;

    logic                  clk   = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic [IN_WIDTH-1:0]   value = '0;
    logic                  busy;
    logic                  valid;
    logic [CHAR_WIDTH-1:0] character;
    logic                  last_char;
    int                    fail_count;
    int                    beats_owed;

    logic [IN_WIDTH-1:0] directed_values [22] = '{
        64'd0,
        64'd1,
        64'hFFFF_FFFF_FFFF_FFFF,
        64'd9,
        -64'sd9,
        64'd10,
        -64'sd10,
        64'd99,
        64'd100,
        64'd12345,
        64'h7FFF_FFFF_FFFF_FFFF,
        64'h8000_0000_0000_0000,
        64'h8000_0000_0000_0001,
        64'd999999999999999999,
        64'd1000000000000000000,
        -64'sd1000000000000000000,
        -64'sd999999999999999999,
        64'h5555_5555_5555_5555,
        64'hAAAA_AAAA_AAAA_AAAA,
        64'd1234567890123456789,
        -64'sd1234567890123456789,
        64'd9000000000000000009
    };

    int idle_pct [3] = '{0, 54, 22};

    signed_int_to_decimal_text_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .value     (value),
        .busy      (busy),
        .valid     (valid),
        .character (character),
        .last_char (last_char)
    );

    sitd_text_checker u_text_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .value      (value),
        .valid      (valid),
        .character  (character),
        .last_char  (last_char),
        .fail_count (fail_count),
        .beats_owed (beats_owed)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // hold start until the core takes the beat
    task automatic send_number(input logic [IN_WIDTH-1:0] v);
        start <= 1'b1;
        value <= v;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    task automatic sender_gap(input int pct);
        int gap;
        if ($urandom_range(99) < pct)
        begin
            gap   = $urandom_range(1, 120);
            start <= 1'b0;
            repeat (gap)
            begin
                value <= {$urandom, $urandom};
                @(posedge clk);
            end
        end
    endtask

    function automatic logic [IN_WIDTH-1:0] random_number();
        logic [IN_WIDTH-1:0] magnitude;
        logic [IN_WIDTH-1:0] span;
        int                  pick;
        int                  digits;
        pick = $urandom_range(99);
        if (pick < 35)
            return {$urandom, $urandom};
        digits = $urandom_range(1, 19);
        span   = 1;
        repeat (digits)
            span = span * 10;
        if (pick < 75)
            magnitude = {$urandom, $urandom} % span;
        else if (pick < 88)
            magnitude = span - 1;
        else
            magnitude = span / 10;
        return $urandom_range(1) ? -magnitude : magnitude;
    endfunction

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_values[i])
            send_number(directed_values[i]);
        foreach (idle_pct[p])
        begin
            repeat (66)
            begin
                sender_gap(idle_pct[p]);
                send_number(random_number());
            end
        end
        start <= 1'b0;
        @(posedge clk);
        while (beats_owed != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
